// ===== sv/broadcast_multi_queue_overflow_top_assert.svh =====
// Assertion macros for the broadcast multi-queue checker.
`ifndef BROADCAST_MULTI_QUEUE_OVERFLOW_TOP_ASSERT_SVH
`define BROADCAST_MULTI_QUEUE_OVERFLOW_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BMQO_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define BMQO_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/bmqo_pkg.sv =====
// Shared types and constants for the broadcast multi-queue block.
`default_nettype none

package bmqo_pkg;

    localparam int SUB_W      = 3;
    localparam int MASK_W     = 8;
    localparam int WORD_W     = 32;
    localparam int LAG_W      = 32;
    localparam int PEND_W     = 5;
    localparam int DEPTH_W    = 5;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int MAX_SLOTS  = 8;

    localparam logic FUNC_FIRE = 1'b0;
    localparam logic FUNC_PULL = 1'b1;

    localparam logic [MODE_W-1:0] MODE_DROP_OLDEST = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOSSY       = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LOSSLESS    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_OVERFLOW_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_IN_USE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SUB_ENABLE    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PUSH_MASK     = 2'd3;

    typedef struct packed {
        logic capture;
        logic fire_step;
        logic pull_step;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== sv/broadcast_multi_queue_overflow_top.sv =====
// Top level of the broadcast multi-queue block with overflow policies.
// Fire: the slot scan steps through one subscriber slot per cycle (min(NUM_SUBSCRIBERS,8)
//   slots), then the result is loaded into the output register.
// Pull: the queue word is read into rd_reg, then the result is loaded into the output register.
// Loading waits only on an output stall; in_stall blocks new items until the result is loaded.
// Async active-low reset clears state, heads, counts, lags and config; queue memory is not cleared.
`default_nettype none

module broadcast_multi_queue_overflow_top #(
    parameter int NUM_SUBSCRIBERS = 8,
    parameter int QUEUE_DEPTH     = 16,
    parameter int DATA_BITS       = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [bmqo_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bmqo_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            func,
    input  logic [bmqo_pkg::SUB_W-1:0]      subscriber,
    input  logic [bmqo_pkg::WORD_W-1:0]     payload,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            item_valid,
    output logic [bmqo_pkg::WORD_W-1:0]     item_data,
    output logic [bmqo_pkg::PEND_W-1:0]     pending_count,
    output logic [bmqo_pkg::LAG_W-1:0]      lag_count,
    output logic [bmqo_pkg::MASK_W-1:0]     wake_mask,
    output logic [bmqo_pkg::MASK_W-1:0]     overflow_mask,
    output logic                            backpressure
);
    import bmqo_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    bmqo_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .func     (func),
        .in_stall (in_stall),
        .cmd      (cmd),
        .stat     (stat)
    );

    bmqo_dp #(
        .NUM_SUBSCRIBERS (NUM_SUBSCRIBERS),
        .QUEUE_DEPTH     (QUEUE_DEPTH),
        .DATA_BITS       (DATA_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .func          (func),
        .subscriber    (subscriber),
        .payload       (payload),
        .cmd           (cmd),
        .stat          (stat),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .item_valid    (item_valid),
        .item_data     (item_data),
        .pending_count (pending_count),
        .lag_count     (lag_count),
        .wake_mask     (wake_mask),
        .overflow_mask (overflow_mask),
        .backpressure  (backpressure)
    );

endmodule

`default_nettype wire

// ===== sv/bmqo_ctrl.sv =====
// Controller state machine: sequences fire scans, pulls and result hand-off.
`default_nettype none

module bmqo_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               func,
    output logic               in_stall,
    output bmqo_pkg::dp_cmd_t  cmd,
    input  bmqo_pkg::dp_stat_t stat
);
    import bmqo_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FIRE,
        ST_PULL,
        ST_DONE
    } state_t;

    state_t state_reg;
    logic   accept;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= (func == FUNC_FIRE) ? ST_FIRE : ST_PULL;
                    end
                end
                ST_FIRE:
                begin
                    if (stat.scan_last)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_PULL:
                begin
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (stat.out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        cmd.capture   = accept;
        cmd.fire_step = (state_reg == ST_FIRE);
        cmd.pull_step = (state_reg == ST_PULL);
        cmd.load_out  = (state_reg == ST_DONE) && stat.out_free;
    end

endmodule

`default_nettype wire

// ===== sv/bmqo_dp.sv =====
// Datapath: config registers, per-slot queue state, shared queue memory, result register.
`default_nettype none

module bmqo_dp #(
    parameter int NUM_SUBSCRIBERS = 8,
    parameter int QUEUE_DEPTH     = 16,
    parameter int DATA_BITS       = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [bmqo_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bmqo_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            func,
    input  logic [bmqo_pkg::SUB_W-1:0]      subscriber,
    input  logic [bmqo_pkg::WORD_W-1:0]     payload,
    input  bmqo_pkg::dp_cmd_t               cmd,
    output bmqo_pkg::dp_stat_t              stat,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            item_valid,
    output logic [bmqo_pkg::WORD_W-1:0]     item_data,
    output logic [bmqo_pkg::PEND_W-1:0]     pending_count,
    output logic [bmqo_pkg::LAG_W-1:0]      lag_count,
    output logic [bmqo_pkg::MASK_W-1:0]     wake_mask,
    output logic [bmqo_pkg::MASK_W-1:0]     overflow_mask,
    output logic                            backpressure
);
    import bmqo_pkg::*;

    localparam int NSLOT      = (NUM_SUBSCRIBERS < MAX_SLOTS) ? NUM_SUBSCRIBERS : MAX_SLOTS;
    localparam int SLOT_W     = (NSLOT > 1) ? $clog2(NSLOT) : 1;
    localparam int PTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int DREG_W     = (CNT_W > DEPTH_W) ? CNT_W : DEPTH_W;
    localparam int STORE_BITS = (DATA_BITS < WORD_W) ? DATA_BITS : WORD_W;

    // config
    logic [MODE_W-1:0]  mode_reg;
    logic [DREG_W-1:0]  depth_reg;
    logic [MASK_W-1:0]  enable_reg;
    logic [MASK_W-1:0]  push_reg;

    // per-slot state
    logic [PTR_W-1:0]   head_reg  [NSLOT];
    logic [CNT_W-1:0]   count_reg [NSLOT];
    logic [LAG_W-1:0]   lag_reg   [NSLOT];

    logic [STORE_BITS-1:0] mem [NSLOT][QUEUE_DEPTH];
    logic [STORE_BITS-1:0] rd_reg;

    // captured item and work registers
    logic                  func_reg;
    logic [SUB_W-1:0]      sub_reg;
    logic [STORE_BITS-1:0] data_reg;
    logic [SLOT_W-1:0]     scan_reg;
    logic [MASK_W-1:0]     wake_reg;
    logic [MASK_W-1:0]     ovf_reg;
    logic                  bp_reg;
    logic                  pv_reg;
    logic [CNT_W-1:0]      pend_reg;
    logic [LAG_W-1:0]      plag_reg;

    // result register
    logic                  out_valid_reg;
    logic                  item_valid_reg;
    logic [WORD_W-1:0]     item_data_reg;
    logic [PEND_W-1:0]     pending_reg;
    logic [LAG_W-1:0]      lag_out_reg;
    logic [MASK_W-1:0]     wake_out_reg;
    logic [MASK_W-1:0]     ovf_out_reg;
    logic                  bp_out_reg;

    logic [CNT_W-1:0]      cap;
    logic [SLOT_W-1:0]     cur_idx;
    logic                  cur_on;
    logic [PTR_W-1:0]      cur_head;
    logic [CNT_W-1:0]      cur_cnt;
    logic [LAG_W-1:0]      cur_lag;
    logic                  full;
    logic                  drop_mode;
    logic                  lossless_mode;
    logic                  took;
    logic [CNT_W:0]        pos_sum;
    logic [PTR_W-1:0]      wpos;
    logic [PTR_W-1:0]      head_inc;
    logic [PTR_W-1:0]      head_new;
    logic [CNT_W-1:0]      count_new;
    logic [LAG_W-1:0]      lag_new;
    logic                  state_we;
    logic                  mem_we;

    always_comb
    begin
        if (depth_reg == '0)
        begin
            cap = CNT_W'(1);
        end
        else if (depth_reg > DREG_W'(QUEUE_DEPTH))
        begin
            cap = CNT_W'(QUEUE_DEPTH);
        end
        else
        begin
            cap = CNT_W'(depth_reg);
        end
    end

    always_comb
    begin
        drop_mode     = (mode_reg == MODE_DROP_OLDEST);
        lossless_mode = (mode_reg != MODE_DROP_OLDEST) && (mode_reg != MODE_LOSSY);

        cur_idx = cmd.fire_step ? scan_reg : sub_reg[SLOT_W-1:0];
        if (cmd.fire_step)
        begin
            cur_on = enable_reg[scan_reg];
        end
        else
        begin
            cur_on = ({1'b0, sub_reg} < (SUB_W + 1)'(NSLOT)) && enable_reg[sub_reg];
        end
        cur_head = head_reg[cur_idx];
        cur_cnt  = count_reg[cur_idx];
        cur_lag  = lag_reg[cur_idx];
        full     = (cur_cnt >= cap);
        took     = !full || drop_mode;

        pos_sum = (CNT_W + 1)'(cur_head) + (CNT_W + 1)'(cur_cnt);
        if (pos_sum >= (CNT_W + 1)'(QUEUE_DEPTH))
        begin
            pos_sum = pos_sum - (CNT_W + 1)'(QUEUE_DEPTH);
        end
        wpos = PTR_W'(pos_sum);

        head_inc = (cur_head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : cur_head + 1'b1;

        if (cmd.fire_step)
        begin
            // drop-oldest on a full queue: advance head, write at old tail, count unchanged
            head_new  = (full && drop_mode) ? head_inc : cur_head;
            count_new = full ? cur_cnt : cur_cnt + 1'b1;
            lag_new   = (full && (cur_lag != '1)) ? cur_lag + 1'b1 : cur_lag;
            state_we  = cur_on;
        end
        else
        begin
            head_new  = head_inc;
            count_new = cur_cnt - 1'b1;
            lag_new   = cur_lag;
            state_we  = cmd.pull_step && cur_on && (cur_cnt != '0);
        end
        mem_we = cmd.fire_step && cur_on && took;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_DROP_OLDEST;
            depth_reg  <= DREG_W'(QUEUE_DEPTH);
            enable_reg <= '0;
            push_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_OVERFLOW_MODE: mode_reg   <= cfg_data[MODE_W-1:0];
                CFG_DEPTH_IN_USE:  depth_reg  <= DREG_W'(cfg_data[DEPTH_W-1:0]);
                CFG_SUB_ENABLE:    enable_reg <= cfg_data;
                CFG_PUSH_MASK:     push_reg   <= cfg_data;
                default:           mode_reg   <= mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NSLOT; i++)
            begin
                head_reg[i]  <= '0;
                count_reg[i] <= '0;
                lag_reg[i]   <= '0;
            end
        end
        else if (cfg_we && (cfg_index == CFG_SUB_ENABLE))
        begin
            // newly enabled slots start empty with zero lag
            for (int i = 0; i < NSLOT; i++)
            begin
                if (cfg_data[i] && !enable_reg[i])
                begin
                    head_reg[i]  <= '0;
                    count_reg[i] <= '0;
                    lag_reg[i]   <= '0;
                end
            end
        end
        else if (state_we)
        begin
            head_reg[cur_idx]  <= head_new;
            count_reg[cur_idx] <= count_new;
            lag_reg[cur_idx]   <= lag_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[cur_idx][wpos] <= data_reg;
        end
        if (cmd.pull_step)
        begin
            rd_reg <= mem[cur_idx][cur_head];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg <= func;
            sub_reg  <= subscriber;
            data_reg <= payload[STORE_BITS-1:0];
            scan_reg <= '0;
            wake_reg <= '0;
            ovf_reg  <= '0;
            bp_reg   <= 1'b0;
        end
        else if (cmd.fire_step)
        begin
            scan_reg <= scan_reg + 1'b1;
            if (cur_on && full)
            begin
                ovf_reg[scan_reg] <= 1'b1;
                if (lossless_mode)
                begin
                    bp_reg <= 1'b1;
                end
            end
            if (cur_on && took && push_reg[scan_reg])
            begin
                wake_reg[scan_reg] <= 1'b1;
            end
        end
        else if (cmd.pull_step)
        begin
            pv_reg   <= cur_on && (cur_cnt != '0);
            pend_reg <= cur_on ? ((cur_cnt != '0) ? cur_cnt - 1'b1 : cur_cnt) : '0;
            plag_reg <= cur_on ? cur_lag : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            if (func_reg == FUNC_FIRE)
            begin
                item_valid_reg <= 1'b0;
                item_data_reg  <= '0;
                pending_reg    <= '0;
                lag_out_reg    <= '0;
                wake_out_reg   <= wake_reg;
                ovf_out_reg    <= ovf_reg;
                bp_out_reg     <= bp_reg;
            end
            else
            begin
                item_valid_reg <= pv_reg;
                item_data_reg  <= pv_reg ? WORD_W'(rd_reg) : '0;
                pending_reg    <= PEND_W'(pend_reg);
                lag_out_reg    <= plag_reg;
                wake_out_reg   <= '0;
                ovf_out_reg    <= '0;
                bp_out_reg     <= 1'b0;
            end
        end
    end

    assign stat.scan_last = (scan_reg == SLOT_W'(NSLOT - 1));
    assign stat.out_free  = !out_valid_reg || !out_stall;

    assign out_valid     = out_valid_reg;
    assign item_valid    = item_valid_reg;
    assign item_data     = item_data_reg;
    assign pending_count = pending_reg;
    assign lag_count     = lag_out_reg;
    assign wake_mask     = wake_out_reg;
    assign overflow_mask = ovf_out_reg;
    assign backpressure  = bp_out_reg;

endmodule

`default_nettype wire

// ===== sv/bmqo_chk.sv =====
// Port-level checker for the broadcast multi-queue block, bound to the top level.
`default_nettype none

`include "broadcast_multi_queue_overflow_top_assert.svh"

module bmqo_chk (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic                        item_valid,
    input logic [bmqo_pkg::WORD_W-1:0] item_data,
    input logic [bmqo_pkg::MASK_W-1:0] wake_mask,
    input logic [bmqo_pkg::MASK_W-1:0] overflow_mask,
    input logic                        backpressure
);

    `BMQO_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall, "input not stalled after accept")

    `BMQO_ASSERT_NOW(a_pull_no_fire_fields, clk, rst_n, out_valid && item_valid, (wake_mask == '0) && (overflow_mask == '0) && !backpressure, "fire fields set on a pull item")

    `BMQO_ASSERT_NOW(a_bp_needs_overflow, clk, rst_n, out_valid && backpressure, overflow_mask != '0, "backpressure without overflow")

    `BMQO_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(item_data), "stalled result changed")

endmodule

bind broadcast_multi_queue_overflow_top bmqo_chk u_bmqo_chk (.*);

`default_nettype wire
